@@ hw/rtl/ign_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ign_pkg: shared types and helpers for greedy IoU non-maximum suppression
// Payload structs, the token that walks the cell row, and the IoU test.
// ----------------------------------------------------------------------------
package ign_pkg;

    localparam int MAX_KEPT_DEF  = 32;
    localparam int MAX_BOXES_DEF = 1024;

    localparam int COORD_W = 16;
    localparam int SIZE_W  = 15;
    localparam int AREA_W  = 30;
    localparam int UNION_W = 31;
    localparam int THR_W   = 16;
    localparam int NUM_W   = 10;
    localparam int PROD_W  = AREA_W + THR_W + 1;

    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;
    localparam int REG_IDX_W  = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_IOU_THRESHOLD = '0;
    localparam logic [THR_W-1:0]     IOU_THRESHOLD_RST = 16'd29491;

    typedef struct packed {
        logic                      frame_start;
        logic signed [COORD_W-1:0] box_left;
        logic signed [COORD_W-1:0] box_top;
        logic [SIZE_W-1:0]         box_width;
        logic [SIZE_W-1:0]         box_height;
    } t_in;

    typedef struct packed {
        logic             keep;
        logic [NUM_W-1:0] box_number;
        logic             table_overflow;
    } t_out;

    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic [SIZE_W-1:0]         width;
        logic [SIZE_W-1:0]         height;
    } t_box;

    // one box in flight; p_* carry the intersection found by the previous cell
    typedef struct packed {
        logic              valid;
        logic              keep;
        t_box              box;
        logic [AREA_W-1:0] area;
        logic              p_valid;
        logic [AREA_W-1:0] p_inter;
        logic [AREA_W-1:0] p_karea;
    } t_token;

    // inter * 2^16 > thr * union
    function automatic logic ign_suppress(input logic [AREA_W-1:0] area,
                                          input logic [AREA_W-1:0] karea,
                                          input logic [AREA_W-1:0] inter,
                                          input logic [THR_W-1:0]  thr);
        logic [UNION_W-1:0] uni;
        logic [PROD_W-1:0]  lhs;
        logic [PROD_W-1:0]  rhs;
        uni = UNION_W'(area) + UNION_W'(karea) - UNION_W'(inter);
        lhs = {1'b0, inter, {THR_W{1'b0}}};
        rhs = PROD_W'(thr) * PROD_W'(uni);
        return lhs > rhs;
    endfunction

endpackage

@@ hw/rtl/ign_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ign_cell: one kept-box slot of the suppression row
// Holds a kept box and its area, finishes the IoU test of the previous slot
// and computes the intersection of the passing box with its own entry.
// ----------------------------------------------------------------------------
module ign_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_occupied,
    input  logic [ign_pkg::THR_W-1:0]     i_threshold,
    input  ign_pkg::t_token               i_tok,
    output ign_pkg::t_token               o_tok,
    input  logic                          i_wr_en,
    input  ign_pkg::t_box                 i_wr_box,
    input  logic [ign_pkg::AREA_W-1:0]    i_wr_area
);
    import ign_pkg::*;

    t_box              r_box;
    logic [AREA_W-1:0] r_area;
    t_token            r_tok;
    t_token            n_tok;

    logic [SIZE_W-1:0] w_iw;
    logic [SIZE_W-1:0] w_ih;
    logic [AREA_W-1:0] w_inter;
    logic              w_supp;

    // overlap of [a0, a0+al) and [b0, b0+bl), zero when not positive
    function automatic logic [SIZE_W-1:0] overlap(input logic signed [COORD_W-1:0] a0,
                                                   input logic [SIZE_W-1:0]         al,
                                                   input logic signed [COORD_W-1:0] b0,
                                                   input logic [SIZE_W-1:0]         bl);
        logic signed [COORD_W:0]   a_lo;
        logic signed [COORD_W:0]   b_lo;
        logic signed [COORD_W:0]   a_hi;
        logic signed [COORD_W:0]   b_hi;
        logic signed [COORD_W:0]   lo;
        logic signed [COORD_W:0]   hi;
        logic signed [COORD_W+1:0] d;
        a_lo = {a0[COORD_W-1], a0};
        b_lo = {b0[COORD_W-1], b0};
        a_hi = a_lo + $signed({2'b00, al});
        b_hi = b_lo + $signed({2'b00, bl});
        lo   = (a_lo > b_lo) ? a_lo : b_lo;
        hi   = (a_hi < b_hi) ? a_hi : b_hi;
        d    = {hi[COORD_W], hi} - {lo[COORD_W], lo};
        return (d > 0) ? d[SIZE_W-1:0] : '0;
    endfunction

    always_comb begin
        w_iw    = overlap(i_tok.box.left, i_tok.box.width, r_box.left, r_box.width);
        w_ih    = overlap(i_tok.box.top, i_tok.box.height, r_box.top, r_box.height);
        w_inter = {{(AREA_W-SIZE_W){1'b0}}, w_iw} * {{(AREA_W-SIZE_W){1'b0}}, w_ih};
        w_supp  = i_tok.p_valid
                  && ign_suppress(i_tok.area, i_tok.p_karea, i_tok.p_inter, i_threshold);

        n_tok         = i_tok;
        n_tok.keep    = i_tok.keep && !w_supp;
        n_tok.p_valid = i_occupied;
        n_tok.p_inter = w_inter;
        n_tok.p_karea = r_area;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_box  <= i_wr_box;
            r_area <= i_wr_area;
        end
    end

    assign o_tok = r_tok;

endmodule

@@ hw/rtl/ign_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ign_regs: configuration register file
// APB-style slave holding the IoU threshold.
// ----------------------------------------------------------------------------
module ign_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ign_pkg::PADDR_W-1:0]        paddr,
    input  logic [ign_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ign_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    output logic [ign_pkg::THR_W-1:0]          o_iou_threshold
);
    import ign_pkg::*;

    logic [THR_W-1:0]     r_iou_threshold;
    logic [THR_W-1:0]     n_iou_threshold;
    logic [REG_IDX_W-1:0] w_idx;

    assign w_idx  = paddr[PADDR_W-1:2];
    assign pready = 1'b1;

    always_comb begin
        n_iou_threshold = r_iou_threshold;
        if (psel && penable && pwrite && w_idx == REG_IOU_THRESHOLD) begin
            n_iou_threshold = pwdata[THR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iou_threshold <= IOU_THRESHOLD_RST;
        end else begin
            r_iou_threshold <= n_iou_threshold;
        end
    end

    always_comb begin
        prdata = '0;
        if (w_idx == REG_IOU_THRESHOLD) begin
            prdata = {{(APB_DATA_W-THR_W){1'b0}}, r_iou_threshold};
        end
    end

    assign o_iou_threshold = r_iou_threshold;

endmodule

@@ hw/rtl/iou_greedy_nms_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iou_greedy_nms_top: class-agnostic greedy IoU non-maximum suppression
// Boxes come in sorted by score; each is tested against the kept boxes of
// its frame and, when it survives, appended to the kept table.
//
// Input channel: one request per box (frame_start, left, top, width,
// height). Output channel: one result per box (keep, box_number,
// table_overflow), in order. Config: APB-style port, threshold at 0x0.
// The kept table lives in a row of MAX_KEPT cells; a box walks the row one
// cell per cycle while each cell compares it with its own entry.
// A request is registered into the head token, passes the cell registers, and its
// result is registered into the output register. No request is taken while a box
// walks the row, but a request is taken while the previous result still waits in
// the output register.
// Reset clears the kept count and the box counter and sets the threshold (29491).
// When the receiver stalls, one finished result is parked in a spare
// register and no new request is taken until it moves to the output.
// ----------------------------------------------------------------------------
module iou_greedy_nms_top #(
    parameter int MAX_KEPT  = ign_pkg::MAX_KEPT_DEF,
    parameter int MAX_BOXES = ign_pkg::MAX_BOXES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  ign_pkg::t_in                   i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output ign_pkg::t_out                  o_out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ign_pkg::PADDR_W-1:0]    paddr,
    input  logic [ign_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ign_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import ign_pkg::*;

    localparam int KC_W  = $clog2(MAX_KEPT + 1);
    localparam int CNT_W = $clog2(MAX_BOXES);

    logic [THR_W-1:0] w_thr;

    t_token              w_tok [MAX_KEPT+1];
    logic [MAX_KEPT:0]   w_tok_valid;
    logic [MAX_KEPT-1:0] w_occ;
    logic [MAX_KEPT-1:0] w_we;

    t_token            r_head;
    t_token            n_head;
    logic              r_busy;
    logic              n_busy;
    logic [KC_W-1:0]   r_kept_count;
    logic [KC_W-1:0]   n_kept_count;
    logic [CNT_W-1:0]  r_box_counter;
    logic [CNT_W-1:0]  n_box_counter;
    logic [CNT_W-1:0]  r_number;
    logic [CNT_W-1:0]  n_number;
    logic              r_res_valid;
    logic              n_res_valid;
    t_out              r_res;
    t_out              n_res;
    logic              r_out_valid;
    logic              n_out_valid;
    t_out              r_out_data;
    t_out              n_out_data;

    logic              w_in_acc;
    logic              w_out_free;
    t_token            w_last;
    logic              w_keep;
    logic              w_room;
    logic              w_append;
    logic [CNT_W-1:0]  w_base;
    t_out              w_result;

    ign_regs u_regs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_iou_threshold (w_thr)
    );

    assign w_tok[0] = r_head;

    for (genvar g = 0; g < MAX_KEPT; g++) begin : g_cell
        assign w_occ[g] = r_kept_count > KC_W'(g);
        assign w_we[g]  = w_append && (r_kept_count == KC_W'(g));

        ign_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_occupied  (w_occ[g]),
            .i_threshold (w_thr),
            .i_tok       (w_tok[g]),
            .o_tok       (w_tok[g+1]),
            .i_wr_en     (w_we[g]),
            .i_wr_box    (w_last.box),
            .i_wr_area   (w_last.area)
        );
    end

    for (genvar g = 0; g <= MAX_KEPT; g++) begin : g_tv
        assign w_tok_valid[g] = w_tok[g].valid;
    end

    assign o_in_ready = !r_busy;
    assign w_in_acc   = i_in_valid && !r_busy;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_last     = w_tok[MAX_KEPT];

    always_comb begin
        // last slot's test is finished here, after the row
        w_keep   = w_last.keep && !(w_last.p_valid
                   && ign_suppress(w_last.area, w_last.p_karea, w_last.p_inter, w_thr));
        w_room   = r_kept_count < KC_W'(MAX_KEPT);
        w_append = w_last.valid && w_keep && w_room;
        w_base   = i_in_data.frame_start ? '0 : r_box_counter;

        w_result.keep           = w_keep;
        w_result.box_number     = NUM_W'(r_number);
        w_result.table_overflow = w_keep && !w_room;
    end

    always_comb begin
        n_head        = r_head;
        n_head.valid  = 1'b0;
        n_busy        = r_busy;
        n_kept_count  = r_kept_count;
        n_box_counter = r_box_counter;
        n_number      = r_number;
        n_res_valid   = r_res_valid;
        n_res         = r_res;
        n_out_valid   = r_out_valid;
        n_out_data    = r_out_data;

        if (w_in_acc) begin
            n_busy          = 1'b1;
            n_head.valid    = 1'b1;
            n_head.keep     = 1'b1;
            n_head.box.left   = i_in_data.box_left;
            n_head.box.top    = i_in_data.box_top;
            n_head.box.width  = i_in_data.box_width;
            n_head.box.height = i_in_data.box_height;
            n_head.area     = {{(AREA_W-SIZE_W){1'b0}}, i_in_data.box_width}
                              * {{(AREA_W-SIZE_W){1'b0}}, i_in_data.box_height};
            n_head.p_valid  = 1'b0;
            n_head.p_inter  = '0;
            n_head.p_karea  = '0;
            n_number        = w_base;
            // saturate at the last box number
            if (w_base < CNT_W'(MAX_BOXES - 1)) begin
                n_box_counter = w_base + CNT_W'(1);
            end else begin
                n_box_counter = w_base;
            end
            if (i_in_data.frame_start) begin
                n_kept_count = '0;
            end
        end

        if (w_append) begin
            n_kept_count = r_kept_count + KC_W'(1);
        end

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (w_last.valid) begin
            if (w_out_free) begin
                n_out_valid = 1'b1;
                n_out_data  = w_result;
                n_busy      = 1'b0;
            end else begin
                n_res_valid = 1'b1;
                n_res       = w_result;
            end
        end else if (r_res_valid && w_out_free) begin
            n_out_valid = 1'b1;
            n_out_data  = r_res;
            n_res_valid = 1'b0;
            n_busy      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head.valid  <= 1'b0;
            r_busy        <= 1'b0;
            r_kept_count  <= '0;
            r_box_counter <= '0;
            r_res_valid   <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_head        <= n_head;
            r_busy        <= n_busy;
            r_kept_count  <= n_kept_count;
            r_box_counter <= n_box_counter;
            r_res_valid   <= n_res_valid;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_number   <= n_number;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // only one box walks the row at a time
    a_single_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_tok_valid) <= 1)
        else $error("more than one box in the cell row");

    a_token_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last.valid |-> r_busy)
        else $error("box left the row while block idle");

    a_accept_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_head.valid && r_busy))
        else $error("accepted request did not enter the row");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kept_count <= KC_W'(MAX_KEPT))
        else $error("kept count beyond table size");

    a_parked_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> (r_out_valid && r_busy))
        else $error("parked result with free output register");

    a_overflow_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out_data.table_overflow || o_out_data.keep))
        else $error("overflow flagged on a suppressed box");

endmodule
